// ===== rtl/stt_pkg.sv =====
// Shared types and constants of the script text tokenizer.
package stt_pkg;

   localparam int TEXT_BYTE_BITS = 8;
   localparam int KIND_BITS      = 3;
   localparam int START_BITS     = 32;
   localparam int LENGTH_BITS    = 32;
   localparam int TOKEN_LINE_BITS = 24;
   localparam int FIRST_LINE_BITS = 24;

   localparam int REC_SLOTS   = 3;
   localparam int SLOT_BITS   = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [KIND_BITS-1:0] KIND_OPEN   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_STRING = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_OP     = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_END    = 3'd5;

   typedef struct packed {
      logic [TEXT_BYTE_BITS-1:0] text_byte;
      logic                      end_of_text;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]       token_kind;
      logic [START_BITS-1:0]      token_start;
      logic [LENGTH_BITS-1:0]     token_length;
      logic [TOKEN_LINE_BITS-1:0] token_line;
      logic                       unterminated;
      logic                       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]        count;
      rsp_type [REC_SLOTS-1:0]     recs;
   } bundle_type;

endpackage

// ===== rtl/script_text_tokenizer.sv =====
// Top level of the script text tokenizer: scanner, bundle queue and output stage.
//
// Text enters on the request channel (req_valid, req_ready, req_data), one byte per
// request, with end_of_text on the final byte. Token records leave on the response
// channel (rsp_valid, rsp_ready, rsp_data); the record that closes the work of one
// byte carries last_of_run. The csr channel writes the first line number, which
// also reloads the line counter; it is always ready.
// The scanner takes one byte per cycle while the queue has room. The records of a
// byte are stored as one bundle in a four-entry queue, and the first one appears on the
// response side when that bundle is at the head of the queue. The output stage hands out
// one record per cycle while the receiver is ready; a byte that causes no record is not
// queued and does not hold the output. Sustained input rate is one byte per cycle while
// the records average at most one per byte and the receiver stays ready.
// When the receiver stalls, records wait in the queue and bytes are still taken
// until four bundles are pending; then req_ready drops.
// Reset empties the queue, sets the scanner between tokens at offset zero and
// loads the first line number and the line counter with one.
module script_text_tokenizer
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [FIRST_LINE_BITS-1:0] csr_data
);

   logic       push_valid;
   logic       push_ready;
   bundle_type push_data;
   logic       head_valid;
   logic       head_pop;
   bundle_type head_data;

   stt_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS  (LINE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (head_valid),
      .pop       (head_pop),
      .pop_data  (head_data)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_data (head_data),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/stt_front.sv =====
// Scanner that classifies each text byte and builds the records it causes.
module stt_front
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [FIRST_LINE_BITS-1:0] csr_data,
   output logic                       push_valid,
   input  logic                       push_ready,
   output bundle_type                 push_data
);

   localparam int OFF_EXT  = (OFFSET_BITS > START_BITS) ? OFFSET_BITS : START_BITS;
   localparam int LINE_EXT = (LINE_BITS > FIRST_LINE_BITS) ? LINE_BITS : FIRST_LINE_BITS;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_DQUOTE  = 3'd3;
   localparam logic [2:0] MODE_SQUOTE  = 3'd4;
   localparam logic [2:0] MODE_OP      = 3'd5;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

   logic [2:0]                 mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]     offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]     pstart_ff, pstart_in;
   logic [7:0]                 pop_ff, pop_in;
   logic [LINE_BITS-1:0]       line_ff, line_in;
   logic [FIRST_LINE_BITS-1:0] first_ff, first_in;
   logic                       req_acc;
   logic                       csr_acc;
   bundle_type                 bundle;

   function automatic logic is_separator(input logic [7:0] c);
      return c inside {CHAR_SPACE, CHAR_CR, CHAR_FF, CHAR_LF, CHAR_TAB, CHAR_COMMA, CHAR_SEMI};
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      return c inside {CHAR_BANG, CHAR_EQUAL, CHAR_LESS, CHAR_GREATER};
   endfunction

   function automatic logic is_breaking(input logic [7:0] c);
      return is_separator(c) || is_op_char(c) ||
             (c inside {CHAR_LBRACE, CHAR_RBRACE, CHAR_DQUOTE, CHAR_SQUOTE, CHAR_HASH});
   endfunction

   function automatic logic forms_pair(input logic [7:0] first, input logic [7:0] second);
      if (second == CHAR_EQUAL) begin
         return first inside {CHAR_EQUAL, CHAR_LESS, CHAR_GREATER, CHAR_BANG};
      end
      return (first == CHAR_LESS) && (second == CHAR_GREATER);
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [FIRST_LINE_BITS-1:0] v);
      logic [LINE_EXT-1:0] v_ext;
      logic [LINE_EXT-1:0] m_ext;
      v_ext = LINE_EXT'(v);
      m_ext = LINE_EXT'(LINE_MAX);
      return (v_ext > m_ext) ? LINE_MAX : v_ext[LINE_BITS-1:0];
   endfunction

   function automatic rsp_type make_rec(input logic [KIND_BITS-1:0] kind,
                                        input logic [OFFSET_BITS-1:0] start,
                                        input logic [OFFSET_BITS-1:0] len,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic unterm);
      rsp_type             r;
      logic [OFF_EXT-1:0]  s_ext;
      logic [OFF_EXT-1:0]  l_ext;
      logic [LINE_EXT-1:0] n_ext;
      s_ext = OFF_EXT'(start);
      l_ext = OFF_EXT'(len);
      n_ext = LINE_EXT'(line);
      r.token_kind   = kind;
      r.token_start  = s_ext[START_BITS-1:0];
      r.token_length = l_ext[LENGTH_BITS-1:0];
      r.token_line   = n_ext[TOKEN_LINE_BITS-1:0];
      r.unterminated = unterm;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_ready = push_ready;

   always_comb begin
      logic [7:0]             c;
      logic                   last;
      logic [OFFSET_BITS-1:0] nxt;
      logic [2:0]             mode_v;
      logic [LINE_BITS-1:0]   line_v;
      logic [OFFSET_BITS-1:0] pstart_v;
      logic [7:0]             pop_v;
      logic [7:0]             quote;
      logic                   do_start;
      logic [SLOT_BITS-1:0]   n;
      rsp_type [REC_SLOTS-1:0] recs;

      c        = req_data.text_byte;
      last     = req_data.end_of_text;
      nxt      = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + OFFSET_BITS'(1);
      mode_v   = mode_ff;
      line_v   = line_ff;
      pstart_v = pstart_ff;
      pop_v    = pop_ff;
      quote    = (mode_ff == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      do_start = 1'b0;
      n        = '0;
      recs     = '0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (c == CHAR_CR || c == CHAR_LF) begin
               mode_v = MODE_IDLE;
               if (c == CHAR_LF && line_v != LINE_MAX) begin
                  line_v = line_v + LINE_BITS'(1);
               end
            end
         end
         MODE_IDENT: begin
            if (is_breaking(c)) begin
               recs[n] = make_rec(KIND_IDENT, pstart_ff, offset_ff - pstart_ff, line_v, 1'b0);
               n = n + SLOT_BITS'(1);
               mode_v = MODE_IDLE;
               do_start = 1'b1;
            end
         end
         MODE_DQUOTE, MODE_SQUOTE: begin
            if (c == quote) begin
               recs[n] = make_rec(KIND_STRING, pstart_ff, offset_ff - pstart_ff, line_v, 1'b0);
               n = n + SLOT_BITS'(1);
               mode_v = MODE_IDLE;
            end else if (c == CHAR_CR || c == CHAR_LF) begin
               recs[n] = make_rec(KIND_STRING, pstart_ff, offset_ff - pstart_ff, line_v, 1'b1);
               n = n + SLOT_BITS'(1);
               mode_v = MODE_IDLE;
            end
         end
         MODE_OP: begin
            if (forms_pair(pop_ff, c)) begin
               recs[n] = make_rec(KIND_OP, pstart_ff, OFFSET_BITS'(2), line_v, 1'b0);
               n = n + SLOT_BITS'(1);
               mode_v = MODE_IDLE;
            end else begin
               recs[n] = make_rec(KIND_OP, pstart_ff, OFFSET_BITS'(1), line_v, 1'b0);
               n = n + SLOT_BITS'(1);
               mode_v = MODE_IDLE;
               do_start = 1'b1;
            end
         end
         default: begin
            mode_v = MODE_IDLE;
            do_start = 1'b1;
         end
      endcase

      if (do_start) begin
         if (is_separator(c)) begin
            if (c == CHAR_LF && line_v != LINE_MAX) begin
               line_v = line_v + LINE_BITS'(1);
            end
         end else if (c == CHAR_HASH) begin
            mode_v = MODE_COMMENT;
         end else if (c == CHAR_LBRACE) begin
            recs[n] = make_rec(KIND_OPEN, offset_ff, OFFSET_BITS'(1), line_v, 1'b0);
            n = n + SLOT_BITS'(1);
         end else if (c == CHAR_RBRACE) begin
            recs[n] = make_rec(KIND_CLOSE, offset_ff, OFFSET_BITS'(1), line_v, 1'b0);
            n = n + SLOT_BITS'(1);
         end else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
            mode_v = (c == CHAR_DQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
            pstart_v = nxt;
         end else if (is_op_char(c)) begin
            mode_v = MODE_OP;
            pop_v = c;
            pstart_v = offset_ff;
         end else begin
            mode_v = MODE_IDENT;
            pstart_v = offset_ff;
         end
      end

      if (last) begin
         if (mode_v == MODE_IDENT) begin
            recs[n] = make_rec(KIND_IDENT, pstart_v, nxt - pstart_v, line_v, 1'b0);
            n = n + SLOT_BITS'(1);
         end else if (mode_v == MODE_DQUOTE || mode_v == MODE_SQUOTE) begin
            recs[n] = make_rec(KIND_STRING, pstart_v, nxt - pstart_v, line_v, 1'b1);
            n = n + SLOT_BITS'(1);
         end else if (mode_v == MODE_OP) begin
            recs[n] = make_rec(KIND_OP, pstart_v, OFFSET_BITS'(1), line_v, 1'b0);
            n = n + SLOT_BITS'(1);
         end
         recs[n] = make_rec(KIND_END, nxt, '0, line_v, 1'b0);
         n = n + SLOT_BITS'(1);
         mode_in   = MODE_IDLE;
         offset_in = '0;
         pstart_in = '0;
         pop_in    = '0;
         line_in   = sat_line(first_ff);
      end else begin
         mode_in   = mode_v;
         offset_in = nxt;
         pstart_in = pstart_v;
         pop_in    = pop_v;
         line_in   = line_v;
      end

      if (csr_acc) begin
         line_in = sat_line(csr_data);
      end
      first_in = csr_acc ? csr_data : first_ff;

      bundle.count = n;
      bundle.recs  = recs;
   end

   assign push_valid = req_valid && (bundle.count != '0);
   assign push_data  = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         pstart_ff <= '0;
         pop_ff    <= '0;
         first_ff  <= FIRST_LINE_BITS'(1);
         line_ff   <= LINE_BITS'(1);
      end else begin
         first_ff <= first_in;
         if (req_acc) begin
            mode_ff   <= mode_in;
            offset_ff <= offset_in;
            pstart_ff <= pstart_in;
            pop_ff    <= pop_in;
         end
         if (req_acc || csr_acc) begin
            line_ff <= line_in;
         end
      end
   end

endmodule

// ===== rtl/stt_queue.sv =====
// Short queue of record bundles between the scanner and the output stage.
module stt_queue
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  bundle_type push_data,
   output logic       pop_valid,
   input  logic       pop,
   output bundle_type pop_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   bundle_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> pop_valid)
      else $error("Bundle removed from an empty queue.");

   assert property (@(posedge clock) disable iff (reset)
                    push && !pop |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("Queue fill count lost a pushed bundle.");

endmodule

// ===== rtl/stt_back.sv =====
// Output stage that hands out the records of each bundle one per cycle while rsp_ready is high.
module stt_back
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head_data,
   output logic       head_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 head_last;
   rsp_type              rec;

   assign head_last = (idx_ff == head_data.count - SLOT_BITS'(1));

   always_comb begin
      rec             = head_data.recs[idx_ff];
      rec.last_of_run = head_last;
   end

   assign rsp_valid = head_valid;
   assign rsp_data  = rec;
   assign head_pop  = head_valid && rsp_ready && head_last;

   always_comb begin
      idx_in = idx_ff;
      if (head_valid && rsp_ready) begin
         idx_in = head_last ? '0 : idx_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) head_valid |-> head_data.count != '0)
      else $error("Empty bundle reached the output stage.");

   assert property (@(posedge clock) disable iff (reset) head_valid |-> idx_ff < head_data.count)
      else $error("Record index ran past the bundle.");

endmodule

// ===== test/script_text_tokenizer_test.sv =====
// Self-checking testbench for the script text tokenizer with a token scoreboard.
module script_text_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 100;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_BANG   = "!";
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_SEMI   = ";";
   localparam logic [7:0] CH_LESS   = "<";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_MORE   = ">";
   localparam logic [7:0] CH_LOW_A  = "a";
   localparam logic [7:0] CH_LOW_Z  = "z";
   localparam logic [7:0] CH_OPEN   = "{";
   localparam logic [7:0] CH_CLOSE  = "}";

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_COMMENT, SCAN_WORD, SCAN_DQUOTE, SCAN_SQUOTE, SCAN_OPERATOR
   } scan_state_e;

   typedef logic [7:0] text_q[$];

   class token_board;
      logic [23:0] first_line;
      logic [23:0] line_now;
      logic [31:0] offset_now;
      logic [31:0] token_begin;
      logic [7:0]  held_op;
      scan_state_e scan;
      rsp_type     tokens_due[$];
      rsp_type     step_out[$];
      int          requests;
      int          tokens_checked;
      int          failures;

      function new();
         first_line = 24'd1;
         requests = 0;
         tokens_checked = 0;
         failures = 0;
         restart();
      endfunction

      function void restart();
         scan = SCAN_IDLE;
         offset_now = '0;
         token_begin = '0;
         held_op = '0;
         line_now = first_line;
      endfunction

      function void set_first_line(logic [23:0] value);
         first_line = value;
         line_now = value;
      endfunction

      function int pending();
         return tokens_due.size();
      endfunction

      function bit is_separator(logic [7:0] c);
         return c == CH_SPACE || c == CH_CR || c == CH_FF || c == CH_LF || c == CH_TAB
            || c == CH_COMMA || c == CH_SEMI;
      endfunction

      function bit is_op_char(logic [7:0] c);
         return c == CH_BANG || c == CH_EQUAL || c == CH_LESS || c == CH_MORE;
      endfunction

      function bit is_breaking(logic [7:0] c);
         return is_separator(c) || is_op_char(c) || c == CH_OPEN || c == CH_CLOSE
            || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_HASH;
      endfunction

      function bit ops_pair(logic [7:0] first, logic [7:0] second);
         if (second == CH_EQUAL) begin
            return first == CH_EQUAL || first == CH_LESS || first == CH_MORE || first == CH_BANG;
         end
         return first == CH_LESS && second == CH_MORE;
      endfunction

      function logic [31:0] following();
         return (offset_now == '1) ? offset_now : offset_now + 32'd1;
      endfunction

      function void bump_line();
         if (line_now != '1) begin
            line_now++;
         end
      endfunction

      function void emit_token(logic [2:0] kind, logic [31:0] start, logic [31:0] len,
                               logic open_end);
         rsp_type rec;
         if (step_out.size() >= REC_SLOTS) begin
            return;
         end
         rec.token_kind = kind;
         rec.token_start = start;
         rec.token_length = len;
         rec.token_line = line_now;
         rec.unterminated = open_end;
         rec.last_of_run = 1'b0;
         step_out.push_back(rec);
      endfunction

      function void begin_token(logic [7:0] c);
         if (is_separator(c)) begin
            if (c == CH_LF) begin
               bump_line();
            end
         end else if (c == CH_HASH) begin
            scan = SCAN_COMMENT;
         end else if (c == CH_OPEN) begin
            emit_token(KIND_OPEN, offset_now, 32'd1, 1'b0);
         end else if (c == CH_CLOSE) begin
            emit_token(KIND_CLOSE, offset_now, 32'd1, 1'b0);
         end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            scan = (c == CH_DQUOTE) ? SCAN_DQUOTE : SCAN_SQUOTE;
            token_begin = following();
         end else if (is_op_char(c)) begin
            scan = SCAN_OPERATOR;
            held_op = c;
            token_begin = offset_now;
         end else begin
            scan = SCAN_WORD;
            token_begin = offset_now;
         end
      endfunction

      function void note_request(req_type r);
         logic [7:0]  c;
         logic [7:0]  quote;
         logic [31:0] nxt;
         rsp_type     rec;
         c = r.text_byte;
         step_out.delete();
         requests++;
         case (scan)
            SCAN_COMMENT: begin
               if (c == CH_CR || c == CH_LF) begin
                  scan = SCAN_IDLE;
                  if (c == CH_LF) begin
                     bump_line();
                  end
               end
            end
            SCAN_WORD: begin
               if (is_breaking(c)) begin
                  emit_token(KIND_IDENT, token_begin, offset_now - token_begin, 1'b0);
                  scan = SCAN_IDLE;
                  begin_token(c);
               end
            end
            SCAN_DQUOTE, SCAN_SQUOTE: begin
               quote = (scan == SCAN_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
               if (c == quote) begin
                  emit_token(KIND_STRING, token_begin, offset_now - token_begin, 1'b0);
                  scan = SCAN_IDLE;
               end else if (c == CH_CR || c == CH_LF) begin
                  emit_token(KIND_STRING, token_begin, offset_now - token_begin, 1'b1);
                  scan = SCAN_IDLE;
               end
            end
            SCAN_OPERATOR: begin
               if (ops_pair(held_op, c)) begin
                  emit_token(KIND_OP, token_begin, 32'd2, 1'b0);
                  scan = SCAN_IDLE;
               end else begin
                  emit_token(KIND_OP, token_begin, 32'd1, 1'b0);
                  scan = SCAN_IDLE;
                  begin_token(c);
               end
            end
            default: begin
               scan = SCAN_IDLE;
               begin_token(c);
            end
         endcase
         if (r.end_of_text) begin
            nxt = following();
            if (scan == SCAN_WORD) begin
               emit_token(KIND_IDENT, token_begin, nxt - token_begin, 1'b0);
            end else if (scan == SCAN_DQUOTE || scan == SCAN_SQUOTE) begin
               emit_token(KIND_STRING, token_begin, nxt - token_begin, 1'b1);
            end else if (scan == SCAN_OPERATOR) begin
               emit_token(KIND_OP, token_begin, 32'd1, 1'b0);
            end
            emit_token(KIND_END, nxt, 32'd0, 1'b0);
            restart();
         end else begin
            offset_now = following();
         end
         if (step_out.size() > 0) begin
            rec = step_out.pop_back();
            rec.last_of_run = 1'b1;
            step_out.push_back(rec);
         end
         foreach (step_out[i]) begin
            tokens_due.push_back(step_out[i]);
         end
      endfunction

      task report(string what);
         $display("MISMATCH record %0d: %s", tokens_checked, what);
         failures++;
      endtask

      task check_token(rsp_type got);
         rsp_type want;
         tokens_checked++;
         if (tokens_due.size() == 0) begin
            report($sformatf("unexpected record kind %0d start %0d length %0d",
                             got.token_kind, got.token_start, got.token_length));
            return;
         end
         want = tokens_due.pop_front();
         if (got.token_kind !== want.token_kind) begin
            report($sformatf("kind %0d, expected %0d", got.token_kind, want.token_kind));
         end
         if (got.token_start !== want.token_start) begin
            report($sformatf("start %0d, expected %0d", got.token_start, want.token_start));
         end
         if (got.token_length !== want.token_length) begin
            report($sformatf("length %0d, expected %0d", got.token_length, want.token_length));
         end
         if (got.token_line !== want.token_line) begin
            report($sformatf("line %0d, expected %0d", got.token_line, want.token_line));
         end
         if (got.unterminated !== want.unterminated) begin
            report($sformatf("unterminated %b, expected %b", got.unterminated,
                             want.unterminated));
         end
         if (got.last_of_run !== want.last_of_run) begin
            report($sformatf("last_of_run %b, expected %b", got.last_of_run, want.last_of_run));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [FIRST_LINE_BITS-1:0] csr_data = '0;

   token_board board;
   int send_idle = 0;
   int recv_idle = 0;
   int texts_sent = 0;
   int settings_used = 0;
   int cycles = 0;

   script_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("script_text_tokenizer_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_token(rsp_data);
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{text_byte: b, end_of_text: eot};
      do @(posedge clock); while (!req_ready);
      board.note_request('{text_byte: b, end_of_text: eot});
   endtask

   task automatic send_text(input text_q text);
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
      texts_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_first_line(input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_first_line(value);
      settings_used++;
   endtask

   function automatic void append_str(ref text_q q, input string s);
      for (int i = 0; i < s.len(); i++) begin
         q.push_back(s[i]);
      end
   endfunction

   function automatic logic [7:0] plain_byte(input bit no_newline, input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ((no_newline && (b == CH_CR || b == CH_LF)) || b == avoid) begin
         b = CH_LOW_A;
      end
      return b;
   endfunction

   function automatic text_q random_text();
      text_q      q;
      int         target;
      logic [7:0] b;
      logic [7:0] quote;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      while (q.size() < target) begin
         case ($urandom_range(0, 13))
            0, 1: begin
               repeat ($urandom_range(1, 5)) begin
                  b = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(CH_LOW_A, CH_LOW_Z));
                  if (board.is_breaking(b)) begin
                     b = CH_LOW_Z;
                  end
                  q.push_back(b);
               end
            end
            2: begin
               case ($urandom_range(0, 6))
                  0: q.push_back(CH_SPACE);
                  1: q.push_back(CH_CR);
                  2: q.push_back(CH_FF);
                  3: q.push_back(CH_LF);
                  4: q.push_back(CH_TAB);
                  5: q.push_back(CH_COMMA);
                  default: q.push_back(CH_SEMI);
               endcase
            end
            3: q.push_back(CH_OPEN);
            4: q.push_back(CH_CLOSE);
            5: begin
               case ($urandom_range(0, 4))
                  0: append_str(q, "==");
                  1: append_str(q, "<=");
                  2: append_str(q, ">=");
                  3: append_str(q, "<>");
                  default: append_str(q, "!=");
               endcase
            end
            6: begin
               case ($urandom_range(0, 3))
                  0: q.push_back(CH_BANG);
                  1: q.push_back(CH_EQUAL);
                  2: q.push_back(CH_LESS);
                  default: q.push_back(CH_MORE);
               endcase
            end
            7, 8: begin
               quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
               q.push_back(quote);
               repeat ($urandom_range(0, 4)) q.push_back(plain_byte(1'b1, quote));
               case ($urandom_range(0, 5))
                  4: q.push_back(CH_CR);
                  5: q.push_back(CH_LF);
                  default: q.push_back(quote);
               endcase
            end
            9: begin
               q.push_back(CH_HASH);
               repeat ($urandom_range(0, 4)) q.push_back(plain_byte(1'b1, CH_HASH));
               q.push_back($urandom_range(0, 3) == 0 ? CH_CR : CH_LF);
            end
            10: q.push_back(CH_LF);
            11: q.push_back(CH_SPACE);
            default: q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      return q;
   endfunction

   task automatic run_phase(input int s_idle, input int r_idle, input logic [23:0] first_line,
                            input bit squeeze);
      text_q q;
      int    sent;
      bit    squeezed;
      sent = 0;
      squeezed = 1'b0;
      wait_drained();
      write_first_line(first_line);
      send_idle = s_idle;
      recv_idle = r_idle;
      while (sent < PHASE_BYTES) begin
         if (squeeze && !squeezed && sent >= PHASE_BYTES / 2) begin
            wait_drained();
            squeezed = 1'b1;
         end
         q = random_text();
         send_text(q);
         sent += q.size();
      end
   endtask

   initial begin
      text_q t;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      append_str(t, "{ab<=\"s\"!>");
      send_text(t);
      t = {};
      append_str(t, "#\n'x");
      t.push_back(CH_CR);
      append_str(t, "}<>!=\"");
      send_text(t);
      t = {};
      t.push_back(8'hFF);
      append_str(t, "==");
      t.push_back(CH_TAB);
      t.push_back(8'h00);
      t.push_back(CH_COMMA);
      t.push_back(CH_FF);
      append_str(t, ";\"q");
      send_text(t);
      t = {};
      append_str(t, "\"k\nz");
      send_text(t);

      run_phase(24, 79, 24'd0, 1'b0);
      run_phase(79, 24, 24'hFFFFFF, 1'b1);
      run_phase(0, 0, 24'($urandom_range(2, 24'hFFFFFD)), 1'b0);
      run_phase(0, 0, 24'hFFFFFE, 1'b0);
      wait_drained();

      $display("Tokenized %0d bytes in %0d texts, checked %0d records under %0d line settings.",
               board.requests, texts_sent, board.tokens_checked, settings_used);
      $display("Field mismatches seen: %0d.", board.failures);
      if (board.failures == 0) begin
         $display("script_text_tokenizer_test OK");
      end else begin
         $display("script_text_tokenizer_test NOT OK");
      end
      $finish;
   end
endmodule

// ===== script_text_tokenizer.f =====
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/script_text_tokenizer.sv
test/script_text_tokenizer_test.sv
